// File: src/tcw_pkg.sv
// Shared types and constants for the text console character writer.
// Holds field widths, character codes, register indexes and the structs
// passed between the top level, the engine and the stacks. No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

  // Video memory size; absolute addresses wrap at this count
  localparam int unsigned VIDEO_CELL_COUNT = 16384;
  localparam int unsigned OFS_W   = $clog2(VIDEO_CELL_COUNT);
  localparam int unsigned CELLS_W = OFS_W + 1;
  localparam int unsigned SUM_W   = OFS_W + 3;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned ATTR_W  = 8;
  localparam int unsigned FCNT_W  = 7;

  // Region size is clamped to the video memory size
  localparam logic [CELLS_W-1:0] CELLS_LIMIT = CELLS_W'(VIDEO_CELL_COUNT);

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  // A tab always covers this many cells
  localparam logic [OFS_W-1:0] TAB_CELLS = OFS_W'(4);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = CELLS_W;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_ORIGIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_CELLS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHLIGHT_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_ATTR       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_ATTR       = 3'd5;

  // Output word: 66 payload bits padded to whole bytes
  localparam int unsigned RES_W       = 3 * OFS_W + FCNT_W + CHAR_W + ATTR_W + 1;
  localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  typedef struct packed {
    logic [OFS_W-1:0]   region_origin;
    logic [CELLS_W-1:0] region_cells;
    logic               highlight_mode;
    logic [ATTR_W-1:0]  default_attribute;
    logic [ATTR_W-1:0]  red_attribute;
    logic [ATTR_W-1:0]  tab_attribute;
  } cfg_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_stat_t;

  typedef struct packed {
    logic [OFS_W-1:0]  fill_address;
    logic [FCNT_W-1:0] fill_count;
    logic [CHAR_W-1:0] fill_char;
    logic [ATTR_W-1:0] fill_attr;
    logic [OFS_W-1:0]  cursor_address;
    logic [OFS_W-1:0]  screen_start;
    logic              stack_full;
  } result_t;

  // Region offset to absolute cell, wrapping at the video memory size
  function automatic logic [OFS_W-1:0] abs_addr(input logic [OFS_W-1:0] origin,
                                                input logic [OFS_W-1:0] ofs);
    return origin + ofs;
  endfunction

endpackage

// File: src/tcw_stack.sv
// Record stack for the character writer, with the top entry in a register.
// Entries live in a memory; the entry below the top is prefetched each cycle
// so a pop takes the new top straight from a register. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_stack
  import tcw_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stk_ctrl_t        ctrl_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] top_o,
  output stk_stat_t        stat_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [CNT_W-1:0] count_q, count_d;
  logic [WIDTH-1:0] top_q, below_q;
  logic [CNT_W-1:0] rd_ptr;
  logic             do_push, do_pop;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == DEPTH_C);
  assign top_o        = top_q;

  // Drop pushes onto a full stack and pops from an empty one
  assign do_push = ctrl_i.push && !stat_o.full;
  assign do_pop  = ctrl_i.pop && !stat_o.empty;

  always_comb begin
    count_d = count_q;
    if (do_push) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Entry just below the next top
  assign rd_ptr = count_d - CNT_W'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Hold the top entry; a pop takes the prefetched entry below
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      top_q <= data_i;
    end else if (do_pop) begin
      top_q <= below_q;
    end
  end

  // Write at the push slot, prefetch below the next top
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[count_q[IDX_W-1:0]] <= data_i;
    end
    below_q <= mem[rd_ptr[IDX_W-1:0]];
  end

  ap_no_push_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.push && ctrl_i.pop))
    else $error("stack: push and pop in the same cycle");

  ap_no_empty_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> (count_q != '0))
    else $error("stack: pop requested while empty");

  ap_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("stack: count beyond depth");

endmodule

// File: src/tcw_engine.sv
// Cursor engine of the character writer: cursor, column and view start
// registers, the tab and newline stacks, and the per-character decode.
// Depends on tcw_pkg and tcw_stack.
`timescale 1ns / 1ps

module tcw_engine
  import tcw_pkg::*;
#(
  parameter int unsigned LINE_CELLS          = 80,
  parameter int unsigned SCREEN_CELL_COUNT   = 2000,
  parameter int unsigned TAB_STACK_DEPTH     = 256,
  parameter int unsigned NEWLINE_STACK_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [CHAR_W-1:0] char_i,
  input  cfg_t              cfg_i,
  output result_t           res_o
);

  localparam int unsigned COL_W  = $clog2(LINE_CELLS);
  localparam int unsigned COLX_W = COL_W + 1;
  localparam int unsigned NL_W   = COL_W + 2 * OFS_W;
  // A move adds at most one line, so two line steps restore the view
  localparam int unsigned SCROLL_STEPS = 2;

  localparam logic [SUM_W-1:0]  LINE_X   = SUM_W'(LINE_CELLS);
  localparam logic [SUM_W-1:0]  SCREEN_X = SUM_W'(SCREEN_CELL_COUNT);
  localparam logic [OFS_W-1:0]  LINE_O   = OFS_W'(LINE_CELLS);
  localparam logic [COLX_W-1:0] LINE_CX  = COLX_W'(LINE_CELLS);
  localparam logic [COLX_W-1:0] TAB_CX   = COLX_W'(4);

  logic [OFS_W-1:0] cur_q, cur_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [OFS_W-1:0] start_q, start_d;

  stk_ctrl_t        tab_ctrl, nl_ctrl;
  stk_stat_t        tab_stat, nl_stat;
  logic [OFS_W-1:0] tab_top;
  logic [NL_W-1:0]  nl_top, nl_push;

  logic [CELLS_W-1:0] cells;
  logic [SUM_W-1:0]   cells_x, cur_x;
  logic [COLX_W-1:0]  col_x;
  logic [COL_W-1:0]   nl_before_col;
  logic [OFS_W-1:0]   nl_before, nl_after, nl_next;
  logic [CELLS_W-1:0] tab_sum;
  logic               tab_hit, nl_hit;

  logic [OFS_W-1:0]  f_start;
  logic [FCNT_W-1:0] f_count;
  logic [CHAR_W-1:0] f_char;
  logic [ATTR_W-1:0] f_attr;
  logic              f_full;

  assign cells   = (cfg_i.region_cells > CELLS_LIMIT) ? CELLS_LIMIT : cfg_i.region_cells;
  assign cells_x = SUM_W'(cells);
  assign cur_x   = SUM_W'(cur_q);
  assign col_x   = COLX_W'(col_q);

  assign {nl_before_col, nl_before, nl_after} = nl_top;

  // Start of the next line and the record kept for undoing it
  assign nl_next = cur_q - OFS_W'(col_q) + LINE_O;
  assign nl_push = {col_q, cur_q, nl_next};
  assign tab_sum = CELLS_W'(cur_q) + CELLS_W'(TAB_CELLS);

  // Backspace matches the last tab first, then the last newline
  assign tab_hit = !tab_stat.empty && (tab_top == cur_q) && (cur_q >= TAB_CELLS);
  assign nl_hit  = !tab_hit && !nl_stat.empty && (nl_after == cur_q) && (nl_before <= cur_q);

  // Decode the character into a cell fill and a cursor move
  always_comb begin
    cur_d    = cur_q;
    col_d    = col_q;
    f_start  = cur_q;
    f_count  = '0;
    f_char   = CH_SPACE;
    f_attr   = cfg_i.default_attribute;
    f_full   = 1'b0;
    tab_ctrl = '0;
    nl_ctrl  = '0;
    unique case (char_i)
      CH_NEWLINE: begin
        if (cur_x + LINE_X < cells_x) begin
          nl_ctrl.push = en_i;
          f_full       = nl_stat.full;
          cur_d        = nl_next;
          col_d        = '0;
        end
      end
      CH_BACKSPACE: begin
        if (tab_hit) begin
          tab_ctrl.pop = en_i;
          cur_d        = cur_q - TAB_CELLS;
          col_d        = (col_x >= TAB_CX) ? COL_W'(col_x - TAB_CX)
                                           : COL_W'(col_x + LINE_CX - TAB_CX);
          f_start      = cur_d;
          f_count      = FCNT_W'(TAB_CELLS);
        end else if (nl_hit) begin
          nl_ctrl.pop  = en_i;
          cur_d        = nl_before;
          col_d        = nl_before_col;
          f_start      = nl_before;
          f_count      = FCNT_W'(cur_q - nl_before);
        end else if (cur_q != '0) begin
          cur_d        = cur_q - OFS_W'(1);
          col_d        = (col_q == '0) ? COL_W'(LINE_CX - COLX_W'(1))
                                       : col_q - COL_W'(1);
          f_start      = cur_d;
          f_count      = FCNT_W'(1);
        end
      end
      CH_TAB: begin
        if (cur_x + SUM_W'(TAB_CELLS) <= cells_x) begin
          tab_ctrl.push = en_i;
          f_full        = tab_stat.full;
          f_count       = FCNT_W'(TAB_CELLS);
          f_attr        = cfg_i.tab_attribute;
          cur_d         = tab_sum[OFS_W-1:0];
          // A tab that ends exactly at the top of the offset range wraps to zero
          if (tab_sum[OFS_W]) begin
            col_d = '0;
          end else if (col_x + TAB_CX >= LINE_CX) begin
            col_d = COL_W'(col_x + TAB_CX - LINE_CX);
          end else begin
            col_d = COL_W'(col_x + TAB_CX);
          end
        end
      end
      default: begin
        if (cur_x + SUM_W'(1) < cells_x) begin
          f_count = FCNT_W'(1);
          f_char  = char_i;
          f_attr  = cfg_i.highlight_mode ? cfg_i.red_attribute : cfg_i.default_attribute;
          cur_d   = cur_q + OFS_W'(1);
          col_d   = (col_x + COLX_W'(1) == LINE_CX) ? '0 : col_q + COL_W'(1);
        end
      end
    endcase
  end

  // Scroll the view down a line at a time while the region has room
  always_comb begin
    start_d = start_q;
    for (int i = 0; i < SCROLL_STEPS; i++) begin
      if ((SUM_W'(cur_d) >= SUM_W'(start_d) + SCREEN_X) &&
          (SUM_W'(start_d) + SCREEN_X < cells_x)) begin
        start_d = start_d + LINE_O;
      end
    end
  end

  // Assemble the result; an item without a fill reports the cursor
  always_comb begin
    res_o.fill_count     = f_count;
    res_o.fill_address   = abs_addr(cfg_i.region_origin,
                                    (f_count == '0) ? cur_d : f_start);
    res_o.fill_char      = (f_count == '0) ? '0 : f_char;
    res_o.fill_attr      = (f_count == '0) ? '0 : f_attr;
    res_o.cursor_address = abs_addr(cfg_i.region_origin, cur_d);
    res_o.screen_start   = abs_addr(cfg_i.region_origin, start_d);
    res_o.stack_full     = f_full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      col_q   <= '0;
      start_q <= '0;
    end else if (en_i) begin
      cur_q   <= cur_d;
      col_q   <= col_d;
      start_q <= start_d;
    end
  end

  tcw_stack #(
    .DEPTH (TAB_STACK_DEPTH),
    .WIDTH (OFS_W)
  ) u_tab_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (tab_ctrl),
    .data_i (cur_d),
    .top_o  (tab_top),
    .stat_o (tab_stat)
  );

  tcw_stack #(
    .DEPTH (NEWLINE_STACK_DEPTH),
    .WIDTH (NL_W)
  ) u_nl_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (nl_ctrl),
    .data_i (nl_push),
    .top_o  (nl_top),
    .stat_o (nl_stat)
  );

endmodule

// File: src/text_console_char_writer_top.sv
// Top level of the text console character writer: configuration registers,
// input word register, output word register and the stream handshake.
// Depends on tcw_pkg and tcw_engine.
//
// Usage: character bytes arrive on the s_axis channel, one per word. Each
// accepted character yields exactly one word on m_axis: a cell fill command
// (address, count, character, attribute), the cursor and view start after
// the character, and a flag for a dropped tab or newline record.
// An accepted character is held in the input register; the engine then works
// out the result and loads the output register. Throughput is one character
// per cycle while the receiver does not stall; the cursor, column and view
// start registers plus the stack top registers close the loop from one
// character to the next, with the entry under each stack top prefetched
// from its memory.
// A stalled receiver holds the output word; the input register then keeps
// one more character, after which s_axis_tready drops until the output
// moves. Reset clears both registers and stacks, sets cursor and view start
// to the region origin and restores configuration defaults. Configuration
// writes take effect at once; the user must make them while idle (unchecked).
`timescale 1ns / 1ps

module text_console_char_writer_top
  import tcw_pkg::*;
#(
  parameter int unsigned LINE_CELLS          = 80,
  parameter int unsigned SCREEN_CELL_COUNT   = 2000,
  parameter int unsigned TAB_STACK_DEPTH     = 256,
  parameter int unsigned NEWLINE_STACK_DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // Character input
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [CHAR_W-1:0]      s_axis_tdata,   // [7:0] char_code
  // Fill command output
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [13:0] fill_address, [20:14] fill_count, [28:21] fill_char,
  // [36:29] fill_attr, [50:37] cursor_address, [64:51] screen_start,
  // [65] stack_full, [71:66] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned PAD_W = OUT_TDATA_W - RES_W;

  cfg_t              cfg_q;
  logic              in_valid_q;
  logic [CHAR_W-1:0] in_char_q;
  logic              out_valid_q;
  result_t           out_res_q;
  result_t           res;
  logic              advance, fire;

  // Output register frees up when empty or taken this cycle
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.region_origin     <= '0;
      cfg_q.region_cells      <= CELLS_W'(5461);
      cfg_q.highlight_mode    <= 1'b0;
      cfg_q.default_attribute <= ATTR_W'(7);
      cfg_q.red_attribute     <= ATTR_W'(4);
      cfg_q.tab_attribute     <= ATTR_W'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_REGION_ORIGIN:  cfg_q.region_origin     <= cfg_wdata_i[OFS_W-1:0];
        CFG_REGION_CELLS:   cfg_q.region_cells      <= cfg_wdata_i[CELLS_W-1:0];
        CFG_HIGHLIGHT_MODE: cfg_q.highlight_mode    <= cfg_wdata_i[0];
        CFG_DEFAULT_ATTR:   cfg_q.default_attribute <= cfg_wdata_i[ATTR_W-1:0];
        CFG_RED_ATTR:       cfg_q.red_attribute     <= cfg_wdata_i[ATTR_W-1:0];
        CFG_TAB_ATTR:       cfg_q.tab_attribute     <= cfg_wdata_i[ATTR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
    end
  end

  tcw_engine #(
    .LINE_CELLS          (LINE_CELLS),
    .SCREEN_CELL_COUNT   (SCREEN_CELL_COUNT),
    .TAB_STACK_DEPTH     (TAB_STACK_DEPTH),
    .NEWLINE_STACK_DEPTH (NEWLINE_STACK_DEPTH)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (fire),
    .char_i (in_char_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}},
                          out_res_q.stack_full,
                          out_res_q.screen_start,
                          out_res_q.cursor_address,
                          out_res_q.fill_attr,
                          out_res_q.fill_char,
                          out_res_q.fill_count,
                          out_res_q.fill_address};

  ap_fire_loads_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("top: processed character did not reach the output register");

  ap_no_fill_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_res_q.fill_count == '0)) |->
      ((out_res_q.fill_char == '0) && (out_res_q.fill_attr == '0) &&
       (out_res_q.fill_address == out_res_q.cursor_address)))
    else $error("top: empty fill carries stray fields");

  ap_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("top: output word changed while stalled");

endmodule

// File: sim/text_console_char_writer_top_test.sv
// Self-checking testbench for text_console_char_writer_top: drives characters
// on the input stream and checks every fill word against a built-in predictor.
// Depends on tcw_pkg and the RTL of the character writer.
`timescale 1ns / 1ps

module text_console_char_writer_top_test;
  import tcw_pkg::*;

  localparam int unsigned LINE_CELLS   = 80;
  localparam int unsigned SCREEN_CELLS = 2000;
  localparam int unsigned TAB_DEPTH    = 256;
  localparam int unsigned NL_DEPTH     = 64;
  localparam int unsigned TAB_SPAN     = 4;
  localparam int unsigned IDLE_PCT     = 38;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // DUT connections, all inputs known from time zero
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [CHAR_W-1:0]      s_data = '0;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;

  // Predictor state: registers, cursor, view start and both undo stacks
  cfg_t                   regs;
  logic [OFS_W-1:0]       cur_ofs = '0;
  logic [OFS_W-1:0]       view_ofs = '0;
  logic [OFS_W-1:0]       tab_end_mem [TAB_DEPTH];
  int unsigned            tab_depth = 0;
  logic [2*OFS_W-1:0]     nl_mem [NL_DEPTH];
  int unsigned            nl_depth = 0;

  result_t                expected_fills [$];
  result_t                seen;
  result_t                want;
  int unsigned            mismatches = 0;
  int unsigned            idle_pct = IDLE_PCT;
  int unsigned            cycle_count = 0;

  text_console_char_writer_top #(
    .LINE_CELLS         (LINE_CELLS),
    .SCREEN_CELL_COUNT  (SCREEN_CELLS),
    .TAB_STACK_DEPTH    (TAB_DEPTH),
    .NEWLINE_STACK_DEPTH(NL_DEPTH)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data)
  );

  always #4 clk = ~clk;

  // Work out the fill word for one character and advance the predictor
  function automatic result_t write_char(input logic [CHAR_W-1:0] code);
    result_t           r;
    int unsigned       cells, cur, view, nxt, prev_ofs, fstart, fcount;
    logic [CHAR_W-1:0] fchar;
    logic [ATTR_W-1:0] fattr;
    logic              dropped, tab_hit, nl_hit;
    cells = (regs.region_cells > CELLS_LIMIT) ? VIDEO_CELL_COUNT : regs.region_cells;
    cur = cur_ofs;
    view = view_ofs;
    fstart = 0;
    fcount = 0;
    fchar = '0;
    fattr = '0;
    dropped = 1'b0;
    tab_hit = 1'b0;
    nl_hit = 1'b0;
    prev_ofs = 0;
    case (code)
      CH_NEWLINE: begin
        if (cells > LINE_CELLS && cur < cells - LINE_CELLS) begin
          nxt = LINE_CELLS * (cur / LINE_CELLS + 1);
          if (nl_depth < NL_DEPTH) begin
            nl_mem[nl_depth] = {OFS_W'(cur), OFS_W'(nxt)};
            nl_depth++;
          end else begin
            dropped = 1'b1;
          end
          cur = nxt % VIDEO_CELL_COUNT;
        end
      end
      CH_BACKSPACE: begin
        // A tab undo wins over a newline undo; an empty stack never matches
        if (tab_depth > 0)
          tab_hit = (tab_end_mem[tab_depth-1] == OFS_W'(cur)) && (cur >= TAB_SPAN);
        if (!tab_hit && nl_depth > 0) begin
          prev_ofs = nl_mem[nl_depth-1][2*OFS_W-1:OFS_W];
          nl_hit = (nl_mem[nl_depth-1][OFS_W-1:0] == OFS_W'(cur)) && (prev_ofs <= cur);
        end
        if (tab_hit) begin
          tab_depth--;
          cur -= TAB_SPAN;
          fstart = cur;
          fcount = TAB_SPAN;
          fchar = CH_SPACE;
          fattr = regs.default_attribute;
        end else if (nl_hit) begin
          nl_depth--;
          fstart = prev_ofs;
          fcount = cur - prev_ofs;
          fchar = CH_SPACE;
          fattr = regs.default_attribute;
          cur = prev_ofs;
        end else if (cur > 0) begin
          cur--;
          fstart = cur;
          fcount = 1;
          fchar = CH_SPACE;
          fattr = regs.default_attribute;
        end
      end
      CH_TAB: begin
        if (cells >= TAB_SPAN && cur <= cells - TAB_SPAN) begin
          fstart = cur;
          fcount = TAB_SPAN;
          fchar = CH_SPACE;
          fattr = regs.tab_attribute;
          cur = (cur + TAB_SPAN) % VIDEO_CELL_COUNT;
          if (tab_depth < TAB_DEPTH) begin
            tab_end_mem[tab_depth] = OFS_W'(cur);
            tab_depth++;
          end else begin
            dropped = 1'b1;
          end
        end
      end
      default: begin
        if (cells >= 1 && cur < cells - 1) begin
          fstart = cur;
          fcount = 1;
          fchar = code;
          fattr = regs.highlight_mode ? regs.red_attribute : regs.default_attribute;
          cur++;
        end
      end
    endcase
    // Scroll one line at a time until the cursor is in view or the region ends
    while (cur >= view + SCREEN_CELLS && view + SCREEN_CELLS < cells)
      view = (view + LINE_CELLS) % VIDEO_CELL_COUNT;
    cur_ofs = OFS_W'(cur);
    view_ofs = OFS_W'(view);
    if (fcount == 0) begin
      fstart = cur;
      fchar = '0;
      fattr = '0;
    end
    r.fill_address   = regs.region_origin + OFS_W'(fstart);
    r.fill_count     = FCNT_W'(fcount);
    r.fill_char      = fchar;
    r.fill_attr      = fattr;
    r.cursor_address = regs.region_origin + cur_ofs;
    r.screen_start   = regs.region_origin + view_ofs;
    r.stack_full     = dropped;
    return r;
  endfunction

  // Mostly editing keys with random content; bs_pct sets the undo pressure
  function automatic logic [CHAR_W-1:0] pick_char(input int unsigned bs_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < bs_pct) return CH_BACKSPACE;
    roll = $urandom_range(99);
    if (roll < 20) return CH_NEWLINE;
    if (roll < 40) return CH_TAB;
    return CHAR_W'($urandom_range(255));
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // Offer one character word, optionally after random idle cycles
  task automatic send_char(input logic [CHAR_W-1:0] code);
    while ($urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= code;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    expected_fills.push_back(write_char(code));
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected word has come out
  task automatic settle();
    s_valid <= 1'b0;
    while (expected_fills.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic write_regs(input logic [OFS_W-1:0] origin, input logic [CELLS_W-1:0] cells,
                            input logic hl, input logic [ATTR_W-1:0] def_a,
                            input logic [ATTR_W-1:0] red_a, input logic [ATTR_W-1:0] tab_a);
    put_reg(CFG_REGION_ORIGIN, CFG_DATA_W'(origin));
    put_reg(CFG_REGION_CELLS, CFG_DATA_W'(cells));
    put_reg(CFG_HIGHLIGHT_MODE, CFG_DATA_W'(hl));
    put_reg(CFG_DEFAULT_ATTR, CFG_DATA_W'(def_a));
    put_reg(CFG_RED_ATTR, CFG_DATA_W'(red_a));
    put_reg(CFG_TAB_ATTR, CFG_DATA_W'(tab_a));
    cfg_we <= 1'b0;
    @(negedge clk);
    regs.region_origin     = origin;
    regs.region_cells      = cells;
    regs.highlight_mode    = hl;
    regs.default_attribute = def_a;
    regs.red_attribute     = red_a;
    regs.tab_attribute     = tab_a;
  endtask

  // One configuration phase followed by a burst of random characters
  task automatic run_setting(input logic [OFS_W-1:0] origin, input logic [CELLS_W-1:0] cells,
                             input logic hl, input logic [ATTR_W-1:0] def_a,
                             input logic [ATTR_W-1:0] red_a, input logic [ATTR_W-1:0] tab_a,
                             input int unsigned bs_pct, input bit quiet,
                             input int unsigned count);
    settle();
    write_regs(origin, cells, hl, def_a, red_a, tab_a);
    idle_pct = quiet ? 0 : IDLE_PCT;
    repeat (count) send_char(pick_char(bs_pct));
    idle_pct = IDLE_PCT;
  endtask

  // Reset defaults: extreme bytes, every edit key and each kind of undo
  task automatic test_directed_edits();
    logic [CHAR_W-1:0] script [21];
    script = '{8'h41, 8'h00, 8'hFF, CH_TAB, CH_BACKSPACE, CH_NEWLINE, CH_BACKSPACE,
               CH_BACKSPACE, CH_BACKSPACE, CH_BACKSPACE, CH_BACKSPACE, CH_TAB, 8'h78,
               CH_BACKSPACE, CH_BACKSPACE, CH_NEWLINE, CH_NEWLINE, CH_BACKSPACE,
               CH_BACKSPACE, 8'h55, 8'hAA};
    foreach (script[i]) send_char(script[i]);
  endtask

  // Regions too small for some or all of the edit keys
  task automatic test_tiny_regions();
    logic [CELLS_W-1:0] sizes [6];
    sizes = '{15'd0, 15'd3, 15'd4, 15'd80, 15'd81, 15'd120};
    foreach (sizes[i])
      run_setting(OFS_W'($urandom), sizes[i], i[0], ATTR_W'($urandom), ATTR_W'($urandom),
                  ATTR_W'($urandom), 25, 1'b0, 20);
  endtask

  // Fill, overflow and unwind both undo stacks
  task automatic test_stack_limits();
    settle();
    write_regs(14'd16000, 15'd16384, 1'b1, 8'h1F, 8'hC4, 8'hFF);
    repeat (TAB_DEPTH + 2) send_char(CH_TAB);
    repeat (TAB_DEPTH + 24) send_char(CH_BACKSPACE);
    repeat (NL_DEPTH) send_char(CH_NEWLINE);
    repeat (NL_DEPTH) send_char(CH_BACKSPACE);
    repeat (NL_DEPTH + 6) send_char(CH_NEWLINE);
    repeat (8) send_char(CH_BACKSPACE);
  endtask

  // Random phases over a spread of settings, one of them without idling
  task automatic test_random_settings();
    run_setting(14'd0, 15'd16384, 1'b0, 8'h00, 8'hFF, 8'h00, 35, 1'b0, 20);
    run_setting(14'd16383, 15'd32767, 1'b1, 8'hFF, 8'h00, 8'hFF, 55, 1'b0, 20);
    run_setting(OFS_W'($urandom), CELLS_W'($urandom_range(16384, 2000)), 1'b1,
                ATTR_W'($urandom), ATTR_W'($urandom), ATTR_W'($urandom), 30, 1'b1, 100);
    run_setting(OFS_W'($urandom), 15'd5461, 1'b0, ATTR_W'($urandom), ATTR_W'($urandom),
                ATTR_W'($urandom), 60, 1'b0, 20);
    run_setting(OFS_W'($urandom), 15'd2000, 1'b1, ATTR_W'($urandom), ATTR_W'($urandom),
                ATTR_W'($urandom), 45, 1'b0, 20);
    run_setting(14'd8191, 15'd16384, 1'b0, ATTR_W'($urandom), ATTR_W'($urandom),
                ATTR_W'($urandom), 35, 1'b0, 20);
    run_setting(OFS_W'($urandom), 15'd20000, 1'($urandom), ATTR_W'($urandom),
                ATTR_W'($urandom), ATTR_W'($urandom), 50, 1'b0, 20);
  endtask

  // Oversized region: walk to its end, hit the scroll limit and wrap a tab
  task automatic test_region_end();
    settle();
    write_regs(14'd16383, 15'd32767, 1'b1, 8'h70, 8'h0F, 8'hAA);
    while (cur_ofs < VIDEO_CELL_COUNT - LINE_CELLS) send_char(CH_NEWLINE);
    repeat (90) send_char(8'h23);
    repeat (3) send_char(CH_BACKSPACE);
    send_char(CH_TAB);
    send_char(CH_BACKSPACE);
    send_char(CH_NEWLINE);
    send_char(8'h7E);
  endtask

  // Receiver stalls at random
  always @(negedge clk) begin
    m_ready <= ($urandom_range(99) >= idle_pct);
  end

  // Compare each output word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) begin
      seen.fill_address   = m_data[13:0];
      seen.fill_count     = m_data[20:14];
      seen.fill_char      = m_data[28:21];
      seen.fill_attr      = m_data[36:29];
      seen.cursor_address = m_data[50:37];
      seen.screen_start   = m_data[64:51];
      seen.stack_full     = m_data[65];
      if (expected_fills.size() == 0) begin
        $display("%0t: word %h arrived with nothing expected", $time, m_data);
        mismatches++;
      end else begin
        want = expected_fills.pop_front();
        check_field("fill_address", want.fill_address, seen.fill_address);
        check_field("fill_count", want.fill_count, seen.fill_count);
        check_field("fill_char", want.fill_char, seen.fill_char);
        check_field("fill_attr", want.fill_attr, seen.fill_attr);
        check_field("cursor_address", want.cursor_address, seen.cursor_address);
        check_field("screen_start", want.screen_start, seen.screen_start);
        check_field("stack_full", want.stack_full, seen.stack_full);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("text_console_char_writer_top verification failed");
      $finish;
    end
  end

  initial begin
    regs.region_origin     = '0;
    regs.region_cells      = 15'd5461;
    regs.highlight_mode    = 1'b0;
    regs.default_attribute = 8'd7;
    regs.red_attribute     = 8'd4;
    regs.tab_attribute     = 8'd2;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_edits();
    test_tiny_regions();
    test_stack_limits();
    test_random_settings();
    test_region_end();
    settle();

    if (mismatches == 0)
      $display("text_console_char_writer_top verification clean");
    else
      $display("text_console_char_writer_top verification failed");
    $finish;
  end

endmodule
